### sv/sdr_pkg.sv
// Shared types, codes and a helper function for the scrolling dirty-rectangle ring.
// No dependencies; imported by sdr_cell, scrolling_dirty_rect_ring_core, the checker and the testbench.
package sdr_pkg;

    localparam int SDR_QUEUE_DEPTH = 32;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_LIST = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] REG_WINDOW_TOP_ROW  = 2'd0;
    localparam logic [1:0] REG_WINDOW_LEFT_COL = 2'd1;
    localparam logic [1:0] REG_WINDOW_ROWS     = 2'd2;

    localparam logic [6:0] WINDOW_ROWS_RESET = 7'd16;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] screen_row;
        logic [7:0] screen_col;
        logic [7:0] width;
        logic [7:0] height;
    } entry_t;

    typedef struct packed {
        logic [7:0] top_row;
        logic [7:0] left_col;
        logic [6:0] rows;
    } window_t;

    // Commands broadcast to every cell of the ring.
    typedef struct packed {
        logic load;
        logic update;
        logic shift;
    } cell_ctrl_t;

    // Screen row of a logical row: rows above the window clamp to its top.
    function automatic logic [7:0] screen_row_of(input logic [7:0] row,
                                                 input logic [7:0] top_row);
        logic [7:0] pos;
        pos = row[7] ? 8'd0 : row;
        return top_row + pos;
    endfunction

endpackage

### sv/scrolling_dirty_rect_ring_core.sv
// Top level of the scrolling dirty-rectangle ring: control sequencer, output
// register and the ring of sdr_cell slots. Depends on sdr_pkg and sdr_cell.
//
// Usage:
// Commands arrive on the input channel (in_valid / in_stall); a command is
// taken when in_valid is high and in_stall is low. Results leave on the
// output channel (out_valid / out_stall) through one output register, and
// last marks the final result of each command. Window registers are written
// through the cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data);
// cfg_ready is always high, and writes are expected only while idle.
// Steps of each command:
//   add   : slot write, then result.
//   tick  : one ring walk: an update step, one rotation of the ring that
//           counts the dropped tiles, retirement of the dropped tiles
//           from the head, then the result.
//   list  : one ring rotation, emitting one rectangle per cycle for the
//           live entries unless stalled; an empty list returns EMPTY.
// The ring rotates one slot per cycle. Reset clears the count, sequencer,
// window registers and out_valid; entry contents and output data are not
// cleared. While the receiver stalls, the output register holds its transfer
// and the ring rotation pauses at the next rectangle.
module scrolling_dirty_rect_ring_core
    import sdr_pkg::*;
#(
    parameter int QUEUE_DEPTH = SDR_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic signed [7:0] tile_row,
    input  logic signed [7:0] tile_col,
    input  logic [7:0] tile_width,
    input  logic [7:0] tile_height,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] rect_row,
    output logic [7:0] rect_col,
    output logic [7:0] rect_width,
    output logic [7:0] rect_height,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(QUEUE_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_TICK_UPD  = 6'b000010,
        S_TICK_SCAN = 6'b000100,
        S_TICK_DROP = 6'b001000,
        S_LIST      = 6'b010000,
        S_RESP      = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] drop_reg, drop_next;
    logic [SW-1:0] step_reg, step_next;
    logic [1:0] pend_reg, pend_next;
    window_t    window_reg, window_next;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg, status_next;
    entry_t     rect_reg, rect_next;
    logic       last_reg, last_next;

    cell_ctrl_t ctrl;
    entry_t     load_entry;
    entry_t     cell_entry [QUEUE_DEPTH];
    logic       cell_hit   [QUEUE_DEPTH];

    logic       accept;
    logic       out_free;
    logic       full;
    logic       step_end;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign step_end  = (step_reg == SW'(QUEUE_DEPTH - 1));

    // Entry built from an add command.
    always_comb
    begin
        load_entry.row        = tile_row;
        load_entry.screen_row = screen_row_of(tile_row, window_reg.top_row);
        load_entry.screen_col = window_reg.left_col + tile_col;
        load_entry.width      = tile_width;
        load_entry.height     = tile_height;
    end

    // Configuration writes; an index beyond the list is ignored.
    always_comb
    begin
        window_next = window_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WINDOW_TOP_ROW:  window_next.top_row  = cfg_data;
                REG_WINDOW_LEFT_COL: window_next.left_col = cfg_data;
                REG_WINDOW_ROWS:     window_next.rows     = cfg_data[6:0];
                default:             window_next          = window_reg;
            endcase
        end
    end

    // Sequencer. The ring always rotates toward cell 0, so after a full
    // rotation the head is back in cell 0; retiring k tiles is k extra steps.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        step_next      = step_reg;
        pend_next      = pend_reg;
        ctrl           = '0;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        rect_next      = rect_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_ADD:
                        begin
                            if (full)
                            begin
                                pend_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.load  = 1'b1;
                                count_next = count_reg + CW'(1);
                                pend_next  = ST_OK;
                            end
                            state_next = S_RESP;
                        end
                        OP_TICK:
                        begin
                            state_next = S_TICK_UPD;
                        end
                        OP_LIST:
                        begin
                            step_next = '0;
                            if (count_reg == '0)
                            begin
                                pend_next  = ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TICK_UPD:
            begin
                ctrl.update = 1'b1;
                step_next   = '0;
                drop_next   = '0;
                state_next  = S_TICK_SCAN;
            end
            S_TICK_SCAN:
            begin
                ctrl.shift = 1'b1;
                drop_next  = drop_reg + CW'(cell_hit[0]);
                step_next  = step_reg + SW'(1);
                if (step_end)
                begin
                    state_next = S_TICK_DROP;
                end
            end
            S_TICK_DROP:
            begin
                if (drop_reg == '0)
                begin
                    pend_next  = ST_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    drop_next  = drop_reg - CW'(1);
                    count_next = count_reg - CW'(1);
                end
            end
            S_LIST:
            begin
                if (CW'(step_reg) < count_reg)
                begin
                    if (out_free)
                    begin
                        ctrl.shift     = 1'b1;
                        out_valid_next = 1'b1;
                        status_next    = ST_OK;
                        rect_next      = cell_entry[0];
                        last_next      = (CW'(step_reg) == count_reg - CW'(1));
                    end
                end
                else
                begin
                    ctrl.shift = 1'b1;
                end
                if (ctrl.shift)
                begin
                    step_next = step_reg + SW'(1);
                    if (step_end)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = pend_reg;
                    rect_next      = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            count_reg          <= '0;
            drop_reg           <= '0;
            step_reg           <= '0;
            pend_reg           <= ST_OK;
            out_valid_reg      <= 1'b0;
            window_reg.top_row  <= 8'd0;
            window_reg.left_col <= 8'd0;
            window_reg.rows     <= WINDOW_ROWS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            step_reg      <= step_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            window_reg    <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rect_reg   <= rect_next;
        last_reg   <= last_next;
    end

    // The ring: cell i takes from cell i+1, and the last cell from cell 0.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        sdr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .live       (CW'(i) < count_reg),
            .sel        (CW'(i) == count_reg),
            .window     (window_reg),
            .load_entry (load_entry),
            .nbr_entry  (cell_entry[(i + 1) % QUEUE_DEPTH]),
            .nbr_hit    (cell_hit[(i + 1) % QUEUE_DEPTH]),
            .entry      (cell_entry[i]),
            .hit        (cell_hit[i])
        );
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign rect_row    = rect_reg.screen_row;
    assign rect_col    = rect_reg.screen_col;
    assign rect_width  = rect_reg.width;
    assign rect_height = rect_reg.height;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("live count exceeds queue depth");

    a_list_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |=> $stable(count_reg))
        else $error("live count changed during list walk");

    a_count_drop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < $past(count_reg)) |-> $past(state_reg == S_TICK_DROP))
        else $error("live count fell outside the drop phase");

    a_drop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK_DROP) |-> (drop_reg <= count_reg))
        else $error("more tiles to drop than are live");
`endif

endmodule

### sv/sdr_cell.sv
// One slot of the rectangle ring: holds an entry, applies the tick update and
// shifts toward the head. Depends on sdr_pkg.
module sdr_cell
    import sdr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       live,
    input  logic       sel,
    input  window_t    window,
    input  entry_t     load_entry,
    input  entry_t     nbr_entry,
    input  logic       nbr_hit,
    output entry_t     entry,
    output logic       hit
);

    entry_t     entry_reg;
    entry_t     entry_next;
    logic       hit_reg;
    logic       hit_next;
    logic [7:0] row_inc;
    logic       reach;
    logic [7:0] srow_new;
    logic [8:0] bottom;
    logic       clip;

    always_comb
    begin
        row_inc  = entry_reg.row + 8'd1;
        reach    = (row_inc == {1'b0, window.rows});
        srow_new = screen_row_of(row_inc, window.top_row);
        bottom   = {1'b0, window.top_row} + {2'b00, window.rows};
        clip     = ({1'b0, srow_new} + {1'b0, entry_reg.height}) > bottom;
    end

    always_comb
    begin
        entry_next = entry_reg;
        hit_next   = hit_reg;
        priority if (ctrl.shift)
        begin
            entry_next = nbr_entry;
            hit_next   = nbr_hit;
        end
        else if (ctrl.update)
        begin
            // Every live tile moves down; a tile that reaches the window
            // height keeps its old screen row and height.
            hit_next = live & reach;
            if (live)
            begin
                entry_next.row = row_inc;
                if (!reach)
                begin
                    entry_next.screen_row = srow_new;
                    if (clip)
                    begin
                        entry_next.height = 8'(bottom - {1'b0, srow_new});
                    end
                end
            end
        end
        else if (ctrl.load && sel)
        begin
            entry_next = load_entry;
        end
        else
        begin
            entry_next = entry_reg;
            hit_next   = hit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

### dv/sdr_ring_checker.sv
// Checker for the scrolling dirty-rectangle ring: watches the command, result and
// window register channels, predicts every result and compares it field by field.
// Depends on sdr_pkg for codes, the entry type and the queue depth.
`timescale 1ns / 1ps

module sdr_ring_checker
    import sdr_pkg::*;
#(
    parameter int DEPTH = SDR_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [7:0] tile_row,
    input  logic [7:0] tile_col,
    input  logic [7:0] tile_width,
    input  logic [7:0] tile_height,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] status,
    input  logic [7:0] rect_row,
    input  logic [7:0] rect_col,
    input  logic [7:0] rect_width,
    input  logic [7:0] rect_height,
    input  logic       last,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] width;
        logic [7:0] height;
        logic       last;
    } rect_result_t;

    logic [7:0]   win_top  = 8'd0;
    logic [7:0]   win_left = 8'd0;
    logic [6:0]   win_rows = WINDOW_ROWS_RESET;
    entry_t       tiles [DEPTH];
    int unsigned  head_slot = 0;
    int unsigned  live_tiles = 0;
    rect_result_t expected_rects [$];
    int           errors = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // Rows above the window sit on its top row.
    function automatic logic [7:0] clamp_to_window(input logic [7:0] row,
                                                   input logic [7:0] top);
        return top + (row[7] ? 8'd0 : row);
    endfunction

    task predict_command(input logic [1:0] op, input logic [7:0] row,
                         input logic [7:0] col, input logic [7:0] width,
                         input logic [7:0] height);
        int unsigned  slot;
        int unsigned  start;
        int unsigned  walk;
        int unsigned  i;
        logic [8:0]   bottom;
        logic [8:0]   reach;
        rect_result_t res;
        res      = '0;
        res.last = 1'b1;
        case (op)
            OP_ADD: begin
                if (live_tiles >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot = (head_slot + live_tiles) % DEPTH;
                    tiles[slot].row        = row;
                    tiles[slot].screen_row = clamp_to_window(row, win_top);
                    tiles[slot].screen_col = win_left + col;
                    tiles[slot].width      = width;
                    tiles[slot].height     = height;
                    live_tiles++;
                    res.status = ST_OK;
                end
                expected_rects.push_back(res);
            end
            OP_TICK: begin
                // The walk covers the tiles live at the start; a drop always
                // retires the head, whichever tile reached the bottom.
                start  = head_slot;
                walk   = live_tiles;
                bottom = {1'b0, win_top} + {2'b00, win_rows};
                for (i = 0; i < walk; i++) begin
                    slot = (start + i) % DEPTH;
                    tiles[slot].row = tiles[slot].row + 8'd1;
                    if (tiles[slot].row == {1'b0, win_rows}) begin
                        live_tiles--;
                        head_slot = (head_slot + 1) % DEPTH;
                    end else begin
                        tiles[slot].screen_row = clamp_to_window(tiles[slot].row, win_top);
                        reach = {1'b0, tiles[slot].screen_row} + {1'b0, tiles[slot].height};
                        if (reach > bottom)
                            tiles[slot].height = bottom[7:0] - tiles[slot].screen_row;
                    end
                end
                res.status = ST_OK;
                expected_rects.push_back(res);
            end
            OP_LIST: begin
                if (live_tiles == 0) begin
                    res.status = ST_EMPTY;
                    expected_rects.push_back(res);
                end else begin
                    for (i = 0; i < live_tiles; i++) begin
                        slot       = (head_slot + i) % DEPTH;
                        res.status = ST_OK;
                        res.row    = tiles[slot].screen_row;
                        res.col    = tiles[slot].screen_col;
                        res.width  = tiles[slot].width;
                        res.height = tiles[slot].height;
                        res.last   = (i + 1 == live_tiles);
                        expected_rects.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk) begin
        rect_result_t want;
        rect_result_t seen;
        if (rst_n) begin
            // Results are checked before the command of this edge is predicted,
            // so a stray result can never borrow a brand-new expectation.
            if (out_valid && !out_stall) begin
                seen = '{status, rect_row, rect_col, rect_width, rect_height, last};
                if (expected_rects.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected result status=%0d row=%0d col=%0d w=%0d h=%0d last=%0d",
                                 $realtime, seen.status, seen.row, seen.col, seen.width,
                                 seen.height, seen.last);
                    errors++;
                end else begin
                    want = expected_rects.pop_front();
                    if (want.status !== seen.status || want.row !== seen.row ||
                        want.col !== seen.col || want.width !== seen.width ||
                        want.height !== seen.height || want.last !== seen.last) begin
                        if (errors < 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected status=%0d row=%0d col=%0d w=%0d h=%0d last=%0d",
                                     want.status, want.row, want.col, want.width,
                                     want.height, want.last);
                            $display("  actual   status=%0d row=%0d col=%0d w=%0d h=%0d last=%0d",
                                     seen.status, seen.row, seen.col, seen.width,
                                     seen.height, seen.last);
                        end
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_command(opcode, tile_row, tile_col, tile_width, tile_height);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WINDOW_TOP_ROW:  win_top  = cfg_data;
                    REG_WINDOW_LEFT_COL: win_left = cfg_data;
                    REG_WINDOW_ROWS:     win_rows = cfg_data[6:0];
                    default: ;
                endcase
            end
        end
        fail_count <= errors;
        pending    <= expected_rects.size();
    end

endmodule

### dv/tb.sv
// Testbench top for scrolling_dirty_rect_ring_core: reset, clock, command and
// window register stimulus, receiver stalls and the final verdict.
// Depends on sdr_pkg, the core and sdr_ring_checker, which does all checking.
`timescale 1ns / 1ps

module tb;
    import sdr_pkg::*;

    localparam int         CLK_PERIOD    = 8;
    localparam int         DEPTH         = SDR_QUEUE_DEPTH;
    // A tick walks the ring once and then retires the dropped tiles; this settle
    // time covers the slowest command with room to spare before any window
    // register write.
    localparam int         SETTLE_CYCLES = 3 * DEPTH + 16;
    localparam int         PHASE_ITEMS   = 10;
    localparam int         PHASES        = 6;
    localparam longint     TIMEOUT_NS    = 64'd5_000_000;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [1:0] opcode      = OP_ADD;
    logic [7:0] tile_row    = 8'd0;
    logic [7:0] tile_col    = 8'd0;
    logic [7:0] tile_width  = 8'd0;
    logic [7:0] tile_height = 8'd0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [1:0] status;
    logic [7:0] rect_row;
    logic [7:0] rect_col;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic       last;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index   = REG_WINDOW_TOP_ROW;
    logic [7:0] cfg_data    = 8'd0;

    int fail_count;
    int pending;

    // Sender burst state and the window height currently programmed, which
    // steers the random tile rows toward the drop boundary.
    int         burst_left = 0;
    bit         steady     = 1'b0;
    logic [6:0] cur_rows   = WINDOW_ROWS_RESET;

    always #(CLK_PERIOD / 2) clk = ~clk;

    scrolling_dirty_rect_ring_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .tile_row   (tile_row),
        .tile_col   (tile_col),
        .tile_width (tile_width),
        .tile_height(tile_height),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .rect_row   (rect_row),
        .rect_col   (rect_col),
        .rect_width (rect_width),
        .rect_height(rect_height),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    sdr_ring_checker #(.DEPTH(DEPTH)) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .tile_row   (tile_row),
        .tile_col   (tile_col),
        .tile_width (tile_width),
        .tile_height(tile_height),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .rect_row   (rect_row),
        .rect_col   (rect_col),
        .rect_width (rect_width),
        .rect_height(rect_height),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: switches at random moments between never stalling,
    // stalling half the time, stalling most of the time and a fixed rhythm
    // that stalls two fifths of the time.
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;

    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_tick % 5) < 2);
        endcase
    end

    // Issues one command. Gaps are opened only at burst boundaries; when the
    // next command follows directly, in_valid simply stays high so that it
    // never gets two assignments in one time step.
    task send_command(input logic [1:0] op, input logic [7:0] row, input logic [7:0] col,
                      input logic [7:0] width, input logic [7:0] height);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        tile_row    <= row;
        tile_col    <= col;
        tile_width  <= width;
        tile_height <= height;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
    endtask

    // Holds cfg_valid high across consecutive writes; the caller lowers it.
    task cfg_write(input logic [1:0] index, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task write_window(input logic [7:0] top, input logic [7:0] left, input logic [6:0] rows);
        cfg_write(REG_WINDOW_TOP_ROW, top);
        cfg_write(REG_WINDOW_LEFT_COL, left);
        cfg_write(REG_WINDOW_ROWS, {1'b0, rows});
        cfg_valid <= 1'b0;
        cur_rows = rows;
    endtask

    // Waits for every predicted result and then lets the core fall idle.
    // The first edge lets the checker's count catch up with the last transfer.
    task wait_idle();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Half the rows start one to five rows above the bottom so that ticks drop tiles;
    // the rest are fully random or just above the window.
    function automatic logic [7:0] pick_row(input logic [6:0] rows);
        case ($urandom_range(0, 5))
            0, 1:    return 8'($urandom_range(0, 255));
            5:       return 8'(0) - 8'($urandom_range(1, 4));
            default: return {1'b0, rows} - 8'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic logic [7:0] pick_height(input logic [6:0] rows);
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, rows + 4));
    endfunction

    // Enough adds to overflow the ring whatever it held before, then a list
    // of the full ring.
    task fill_ring();
        repeat (DEPTH + 2)
            send_command(OP_ADD, pick_row(cur_rows), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), pick_height(cur_rows));
        send_command(OP_LIST, 8'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // One random command; counted is low for the ignored opcode.
    task random_command(output bit counted);
        int pick;
        logic [1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 40)      op = OP_ADD;
        else if (pick < 70) op = OP_TICK;
        else if (pick < 92) op = OP_LIST;
        else                op = OP_UNUSED;
        send_command(op, pick_row(cur_rows), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), pick_height(cur_rows));
        counted = (op != OP_UNUSED);
    endtask

    initial begin
        int  p;
        int  counted_items;
        bit  counted;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, under the reset window: top 0, left 0, 16 rows.
        // Empty list and tick, the ignored opcode, then tiles at the field
        // extremes, one a row above the bottom so the first tick drops it
        // from a non-head position, and one at row 127 that wraps negative.
        send_command(OP_LIST, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_UNUSED, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_ADD, 8'h80, 8'h80, 8'h00, 8'h00);
        send_command(OP_ADD, 8'h7f, 8'h7f, 8'hff, 8'hff);
        send_command(OP_ADD, 8'd15, 8'h00, 8'h01, 8'h01);
        send_command(OP_ADD, 8'hff, 8'hff, 8'haa, 8'h55);
        send_command(OP_ADD, 8'h00, 8'h01, 8'h55, 8'd20);
        send_command(OP_LIST, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_LIST, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_ADD, 8'd14, 8'h40, 8'd3, 8'd3);
        send_command(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_LIST, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
        send_command(OP_LIST, 8'd0, 8'd0, 8'd0, 8'd0);
        in_valid <= 1'b0;

        // Random phases. The window is reprogrammed only once the core is
        // idle; the first phases take the extremes of every register, and the
        // tallest window, where tiles stay longest, also overflows the ring.
        for (p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0:       write_window(8'd255, 8'd255, 7'd127);
                1:       write_window(8'd0, 8'd0, 7'd1);
                2:       write_window(8'd128, 8'd200, 7'd64);
                3:       write_window(8'd240, 8'd17, 7'd3);
                default: write_window(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                      7'($urandom_range(1, 127)));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            if (p == 0 || p == 3)
                fill_ring();
            counted_items = 0;
            while (counted_items < PHASE_ITEMS) begin
                random_command(counted);
                if (counted)
                    counted_items++;
            end
            in_valid <= 1'b0;
        end

        wait_idle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
